// ----- rtl/dbsr_pkg.sv -----
package dbsr_pkg;

   // Payload bytes per frame and the widths fixed by the item fields
   localparam int PAYLOAD_BYTES_DEFAULT = 11;
   localparam int INDEX_W               = 4;
   localparam int BYTE_W                = 8;
   localparam int WORD_W                = 16;
   localparam int BIT_CNT_W             = 3;
   localparam int CSR_INDEX_W           = 2;

   // Pin event codes; code 3 means nothing
   typedef enum logic [1:0] {
      KIND_SELECT_FALL = 2'd0,
      KIND_SELECT_RISE = 2'd1,
      KIND_CLOCK_EDGE  = 2'd2
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE_COMMAND  = 2'd0,
      CSR_WRITE_COMMAND = 2'd1,
      CSR_READ_COMMAND  = 2'd2,
      CSR_BUTTON_WORD   = 2'd3
   } csr_index_type;

   // Command sequence: idle, mode seen, frame open for payload, brightness next
   typedef enum logic [1:0] {
      STAGE_IDLE    = 2'd0,
      STAGE_MODE    = 2'd1,
      STAGE_PAYLOAD = 2'd2,
      STAGE_BRIGHT  = 2'd3
   } stage_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       clock_level;
      logic       data_bit;
   } req_item_type;

   typedef struct packed {
      logic               data_out;
      logic               data_drive;
      logic               payload_valid;
      logic [INDEX_W-1:0] payload_index;
      logic [BYTE_W-1:0]  payload_byte;
      logic               frame_done;
      logic [BYTE_W-1:0]  brightness_byte;
      logic               frame_error;
   } rsp_item_type;

endpackage

// ----- rtl/dbsr_req_if.sv -----
interface dbsr_req_if;
   import dbsr_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       clock_level;
   logic       data_bit;

   modport source (output valid, output kind, output clock_level, output data_bit,
                   input ready);
   modport sink   (input valid, input kind, input clock_level, input data_bit,
                   output ready);
endinterface

// ----- rtl/dbsr_rsp_if.sv -----
interface dbsr_rsp_if;
   import dbsr_pkg::*;

   logic               valid;
   logic               ready;
   logic               data_out;
   logic               data_drive;
   logic               payload_valid;
   logic [INDEX_W-1:0] payload_index;
   logic [BYTE_W-1:0]  payload_byte;
   logic               frame_done;
   logic [BYTE_W-1:0]  brightness_byte;
   logic               frame_error;

   modport source (output valid, output data_out, output data_drive,
                   output payload_valid, output payload_index, output payload_byte,
                   output frame_done, output brightness_byte, output frame_error,
                   input ready);
   modport sink   (input valid, input data_out, input data_drive,
                   input payload_valid, input payload_index, input payload_byte,
                   input frame_done, input brightness_byte, input frame_error,
                   output ready);
endinterface

// ----- rtl/display_bus_slave_receiver.sv -----
// Slave receiver for a select / clock / data display bus.
// req_chan carries one pin event per item (select falls, select rises, or a
// clock edge with its level and the sampled data bit). rsp_chan returns
// exactly one result item per event: the data line drive state and bit,
// a stored payload byte with its index, frame done with the brightness
// byte, and the sticky count error flag.
// Registers are written through csr_write_enable / csr_index / csr_data,
// by the user only while no item is in flight; the block does not enforce it.
// The result of an item is registered and is valid on rsp_chan in the
// cycle after the item is accepted. One item per cycle, set by the single
// result register behind the event decode logic, unless a result is stalled.
// When the receiver stalls, the result register holds its item and a new
// item is still taken in the cycle the held one leaves; req_chan.ready
// drops only while a result waits and rsp_chan.ready is low.
// Reset clears all registers, the bus state and the result register valid.
module display_bus_slave_receiver #(
   parameter int PayloadBytes = dbsr_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [dbsr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dbsr_pkg::WORD_W-1:0]       csr_data,
   dbsr_req_if.sink                          req_chan,
   dbsr_rsp_if.source                        rsp_chan
);
   import dbsr_pkg::*;

   req_item_type req_item;
   rsp_item_type result;
   rsp_item_type out_item;
   logic         accept;
   logic         in_ready;

   assign req_item.kind        = req_chan.kind;
   assign req_item.clock_level = req_chan.clock_level;
   assign req_item.data_bit    = req_chan.data_bit;
   assign req_chan.ready       = in_ready;
   assign accept               = req_chan.valid && in_ready;

   dbsr_core #(
      .PayloadBytes (PayloadBytes)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .accept           (accept),
      .item             (req_item),
      .result           (result)
   );

   dbsr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .result    (result),
      .out_ready (rsp_chan.ready),
      .in_ready  (in_ready),
      .out_valid (rsp_chan.valid),
      .out_item  (out_item)
   );

   assign rsp_chan.data_out        = out_item.data_out;
   assign rsp_chan.data_drive      = out_item.data_drive;
   assign rsp_chan.payload_valid   = out_item.payload_valid;
   assign rsp_chan.payload_index   = out_item.payload_index;
   assign rsp_chan.payload_byte    = out_item.payload_byte;
   assign rsp_chan.frame_done      = out_item.frame_done;
   assign rsp_chan.brightness_byte = out_item.brightness_byte;
   assign rsp_chan.frame_error     = out_item.frame_error;

endmodule

// ----- rtl/dbsr_core.sv -----
module dbsr_core #(
   parameter int PayloadBytes = dbsr_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [dbsr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dbsr_pkg::WORD_W-1:0]       csr_data,
   input  logic                              accept,
   input  dbsr_pkg::req_item_type            item,
   output dbsr_pkg::rsp_item_type            result
);
   import dbsr_pkg::*;

   localparam logic [INDEX_W-1:0] FULL_COUNT = INDEX_W'(PayloadBytes);

   // Configuration registers
   logic [BYTE_W-1:0] mode_command_ff;
   logic [BYTE_W-1:0] write_command_ff;
   logic [BYTE_W-1:0] read_command_ff;
   logic [WORD_W-1:0] button_word_ff;

   // Bus state
   logic                 in_packet_ff,   in_packet_in;
   logic                 driving_ff,     driving_in;
   logic [BYTE_W-1:0]    shift_byte_ff,  shift_byte_in;
   logic [BIT_CNT_W-1:0] bit_counter_ff, bit_counter_in;
   logic [INDEX_W-1:0]   byte_counter_ff, byte_counter_in;
   logic [INDEX_W-1:0]   send_index_ff,  send_index_in;
   stage_type            stage_ff,       stage_in;
   logic                 error_ff,       error_in;

   logic [BYTE_W-1:0]    shifted;
   logic [BIT_CNT_W-1:0] bit_next;
   logic                 error_checked;
   logic                 done;
   logic [INDEX_W-1:0]   out_pos;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_command_ff  <= '0;
         write_command_ff <= '0;
         read_command_ff  <= '0;
         button_word_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE_COMMAND:  mode_command_ff  <= csr_data[BYTE_W-1:0];
            CSR_WRITE_COMMAND: write_command_ff <= csr_data[BYTE_W-1:0];
            CSR_READ_COMMAND:  read_command_ff  <= csr_data[BYTE_W-1:0];
            CSR_BUTTON_WORD:   button_word_ff   <= csr_data;
         endcase
      end
   end

   // Next state for one pin event
   always_comb begin
      in_packet_in    = in_packet_ff;
      driving_in      = driving_ff;
      shift_byte_in   = shift_byte_ff;
      bit_counter_in  = bit_counter_ff;
      byte_counter_in = byte_counter_ff;
      send_index_in   = send_index_ff;
      stage_in        = stage_ff;
      error_checked   = error_ff;
      done            = 1'b0;
      shifted         = {item.data_bit, shift_byte_ff[BYTE_W-1:1]};
      bit_next        = bit_counter_ff + 1'b1;
      result          = '0;

      if (accept) begin
         unique case (item.kind)
            KIND_SELECT_FALL: in_packet_in = 1'b1;
            KIND_SELECT_RISE: begin
               in_packet_in = 1'b0;
               driving_in   = 1'b0;
               if ((byte_counter_ff != FULL_COUNT && byte_counter_ff != '0) ||
                   bit_counter_ff != '0) begin
                  error_checked = 1'b1;
               end
               byte_counter_in = '0;
               bit_counter_in  = '0;
               // Decode last byte; mode wins, then write
               priority if (shift_byte_ff == mode_command_ff) begin
                  stage_in = STAGE_MODE;
               end else if (shift_byte_ff == write_command_ff) begin
                  stage_in = (stage_ff == STAGE_MODE) ? STAGE_PAYLOAD : STAGE_IDLE;
               end else if (stage_ff == STAGE_BRIGHT) begin
                  done                   = 1'b1;
                  result.brightness_byte = shift_byte_ff;
                  stage_in               = STAGE_IDLE;
               end else if (stage_ff == STAGE_PAYLOAD) begin
                  stage_in = STAGE_BRIGHT;
               end else begin
                  stage_in = stage_ff;
               end
            end
            KIND_CLOCK_EDGE: begin
               if (in_packet_ff) begin
                  if (!item.clock_level && driving_ff) begin
                     send_index_in = send_index_ff + 1'b1;
                  end else if (item.clock_level && !driving_ff) begin
                     shift_byte_in  = shifted;
                     bit_counter_in = bit_next;
                     // Byte complete
                     if (bit_next == '0) begin
                        if (stage_ff == STAGE_PAYLOAD) begin
                           if (byte_counter_ff < FULL_COUNT) begin
                              result.payload_valid = 1'b1;
                              result.payload_index = byte_counter_ff;
                              result.payload_byte  = shifted;
                              byte_counter_in      = byte_counter_ff + 1'b1;
                           end else begin
                              error_checked = 1'b1;
                           end
                        end else if (shifted == read_command_ff) begin
                           send_index_in = INDEX_W'(8);
                           driving_in    = 1'b1;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      // Sticky error: reported, then cleared at frame done
      error_in           = done ? 1'b0 : error_checked;
      result.frame_error = error_checked;
      result.frame_done  = done;

      // Driven bit is the one shifted out by the last falling edge
      out_pos            = send_index_in - 1'b1;
      result.data_drive  = driving_in;
      result.data_out    = driving_in & button_word_ff[out_pos];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff    <= 1'b0;
         driving_ff      <= 1'b0;
         shift_byte_ff   <= '0;
         bit_counter_ff  <= '0;
         byte_counter_ff <= '0;
         send_index_ff   <= '0;
         stage_ff        <= STAGE_IDLE;
         error_ff        <= 1'b0;
      end else begin
         in_packet_ff    <= in_packet_in;
         driving_ff      <= driving_in;
         shift_byte_ff   <= shift_byte_in;
         bit_counter_ff  <= bit_counter_in;
         byte_counter_ff <= byte_counter_in;
         send_index_ff   <= send_index_in;
         stage_ff        <= stage_in;
         error_ff        <= error_in;
      end
   end

endmodule

// ----- rtl/dbsr_out_stage.sv -----
module dbsr_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  dbsr_pkg::rsp_item_type result,
   input  logic                   out_ready,
   output logic                   in_ready,
   output logic                   out_valid,
   output dbsr_pkg::rsp_item_type out_item
);
   import dbsr_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // Room when empty or the held item leaves this cycle
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dbsr_pkg::*;

   localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT;
   // Event code 3 carries no meaning on the bus
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int MAX_GAP      = 11;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PRINT_CAP    = 200;
   localparam int ITEM_TARGET  = 1350;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]      csr_data = '0;

   dbsr_req_if req_chan ();
   dbsr_rsp_if rsp_chan ();

   display_bus_slave_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Command and key registers as programmed
   logic [7:0]  mode_cmd  = '0;
   logic [7:0]  write_cmd = '0;
   logic [7:0]  read_cmd  = '0;
   logic [15:0] key_word  = '0;

   // Bus receiver state mirrored by the predictor
   logic       bus_selected = 1'b0;
   logic       line_driven  = 1'b0;
   logic [7:0] rx_shift     = '0;
   logic [2:0] rx_bit_cnt   = '0;
   logic [3:0] rx_byte_cnt  = '0;
   logic [3:0] tx_pos       = '0;
   stage_type  stage        = STAGE_IDLE;
   logic       count_error  = 1'b0;

   rsp_item_type results_due[$];

   int sent_count     = 0;
   int checked_count  = 0;
   int mismatch_count = 0;
   int frames_closed  = 0;
   int reads_started  = 0;
   int settings_used  = 0;
   int quiet_cycles   = 0;
   int hold_request   = 0;
   bit req_idle_on    = 1'b1;
   bit rsp_idle_on    = 1'b1;
   bit req_offered    = 1'b0;

   // Next state and result for one pin event
   function automatic rsp_item_type decode_pin_event(input req_item_type ev);
      rsp_item_type res;
      logic [7:0]   msg;
      logic [3:0]   prev_pos;
      res = '0;
      case (ev.kind)
         KIND_SELECT_FALL: bus_selected = 1'b1;
         KIND_SELECT_RISE: begin
            msg = rx_shift;
            bus_selected = 1'b0;
            line_driven = 1'b0;
            if (rx_byte_cnt != PAYLOAD_BYTES && rx_byte_cnt != 0) count_error = 1'b1;
            if (rx_bit_cnt != 0) count_error = 1'b1;
            rx_byte_cnt = '0;
            rx_bit_cnt = '0;
            // mode wins over write when both match
            if (msg == mode_cmd) begin
               stage = STAGE_MODE;
            end else if (msg == write_cmd) begin
               stage = (stage == STAGE_MODE) ? STAGE_PAYLOAD : STAGE_IDLE;
            end else if (stage == STAGE_BRIGHT) begin
               res.brightness_byte = msg;
               res.frame_done = 1'b1;
               stage = STAGE_IDLE;
               frames_closed++;
            end else if (stage == STAGE_PAYLOAD) begin
               stage = STAGE_BRIGHT;
            end
         end
         KIND_CLOCK_EDGE: if (bus_selected) begin
            if (!ev.clock_level && line_driven) begin
               tx_pos = tx_pos + 4'd1;
            end else if (ev.clock_level && !line_driven) begin
               rx_shift = {ev.data_bit, rx_shift[7:1]};
               rx_bit_cnt = rx_bit_cnt + 3'd1;
               if (rx_bit_cnt == 0) begin
                  if (stage == STAGE_PAYLOAD) begin
                     if (rx_byte_cnt < PAYLOAD_BYTES) begin
                        res.payload_valid = 1'b1;
                        res.payload_index = rx_byte_cnt;
                        res.payload_byte = rx_shift;
                        rx_byte_cnt = rx_byte_cnt + 4'd1;
                     end else begin
                        count_error = 1'b1;
                     end
                  end else if (rx_shift == read_cmd) begin
                     tx_pos = 4'd8;
                     line_driven = 1'b1;
                     reads_started++;
                  end
               end
            end
         end
         default: ;
      endcase
      // error is reported before frame done clears it
      res.frame_error = count_error;
      if (res.frame_done) count_error = 1'b0;
      prev_pos = tx_pos - 4'd1;
      res.data_drive = line_driven;
      res.data_out = line_driven ? key_word[prev_pos] : 1'b0;
      return res;
   endfunction

   function automatic void report_mismatch(input string what, input logic [15:0] got,
                                           input logic [15:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: mismatch on %s: got %0h, expected %0h (result %0d)",
                  $realtime, what, got, want, checked_count);
      mismatch_count++;
   endfunction

   function automatic void check_field(input string what, input logic [15:0] got,
                                       input logic [15:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endfunction

   // Compare one accepted result with the oldest prediction
   task automatic check_result();
      rsp_item_type got;
      rsp_item_type want;
      got.data_out        = rsp_chan.data_out;
      got.data_drive      = rsp_chan.data_drive;
      got.payload_valid   = rsp_chan.payload_valid;
      got.payload_index   = rsp_chan.payload_index;
      got.payload_byte    = rsp_chan.payload_byte;
      got.frame_done      = rsp_chan.frame_done;
      got.brightness_byte = rsp_chan.brightness_byte;
      got.frame_error     = rsp_chan.frame_error;
      checked_count++;
      if (results_due.size() == 0) begin
         report_mismatch("result with none pending", '0, '0);
      end else begin
         want = results_due.pop_front();
         check_field("data_out", 16'(got.data_out), 16'(want.data_out));
         check_field("data_drive", 16'(got.data_drive), 16'(want.data_drive));
         check_field("payload_valid", 16'(got.payload_valid), 16'(want.payload_valid));
         check_field("payload_index", 16'(got.payload_index), 16'(want.payload_index));
         check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
         check_field("frame_done", 16'(got.frame_done), 16'(want.frame_done));
         check_field("brightness_byte", 16'(got.brightness_byte),
                     16'(want.brightness_byte));
         check_field("frame_error", 16'(got.frame_error), 16'(want.frame_error));
      end
   endtask

   // Offer one pin event, wait for it to be taken, record its prediction
   task automatic send_event(input logic [1:0] k, input logic lvl, input logic db);
      int           gap;
      req_item_type ev;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         if (req_offered) req_chan.valid <= 1'b0;
         req_offered = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.kind        <= k;
      req_chan.clock_level <= lvl;
      req_chan.data_bit    <= db;
      req_chan.valid       <= 1'b1;
      req_offered = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      ev.kind = k;
      ev.clock_level = lvl;
      ev.data_bit = db;
      results_due.push_back(decode_pin_event(ev));
      sent_count++;
   endtask

   // Stop offering and wait for every pending result
   task automatic drain_results();
      if (req_offered) req_chan.valid <= 1'b0;
      req_offered = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(posedge clock);
      case (idx)
         CSR_MODE_COMMAND:  mode_cmd = val[7:0];
         CSR_WRITE_COMMAND: write_cmd = val[7:0];
         CSR_READ_COMMAND:  read_cmd = val[7:0];
         CSR_BUTTON_WORD:   key_word = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] m, input logic [7:0] w, input logic [7:0] r,
                             input logic [15:0] k);
      drain_results();
      write_csr(CSR_MODE_COMMAND, {8'h00, m});
      write_csr(CSR_WRITE_COMMAND, {8'h00, w});
      write_csr(CSR_READ_COMMAND, {8'h00, r});
      write_csr(CSR_BUTTON_WORD, k);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Commands show up now and then so frames and reads open by chance
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 15))
         0:       return mode_cmd;
         1:       return write_cmd;
         2:       return read_cmd;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Falling edge then rising edge per bit, LSB first
   task automatic clock_bits(input logic [7:0] b, input int nbits);
      int i;
      for (i = 0; i < nbits; i++) begin
         send_event(KIND_CLOCK_EDGE, 1'b0, 1'($urandom_range(0, 1)));
         send_event(KIND_CLOCK_EDGE, 1'b1, b[i]);
      end
   endtask

   task automatic send_command(input logic [7:0] b, input int nbits);
      send_event(KIND_SELECT_FALL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      clock_bits(b, nbits);
      send_event(KIND_SELECT_RISE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_payload(input int nbytes, input int extra_bits);
      int         i;
      logic [7:0] b;
      send_event(KIND_SELECT_FALL, 1'b1, 1'b0);
      for (i = 0; i < nbytes; i++) begin
         b = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : pick_byte();
         clock_bits(b, 8);
      end
      if (extra_bits > 0) clock_bits(8'($urandom_range(0, 255)), extra_bits);
      send_event(KIND_SELECT_RISE, 1'b0, 1'b1);
   endtask

   task automatic send_frame(input int nbytes, input int extra_bits, input logic [7:0] bright);
      send_command(mode_cmd, 8);
      send_command(write_cmd, 8);
      send_payload(nbytes, extra_bits);
      send_command(bright, 8);
   endtask

   // Read request, then nclk clock periods with the line turned around
   task automatic send_read(input int nclk);
      send_event(KIND_SELECT_FALL, 1'b0, 1'b0);
      clock_bits(read_cmd, 8);
      repeat (nclk) clock_bits(8'($urandom_range(0, 255)), 1);
      send_event(KIND_SELECT_RISE, 1'b1, 1'b1);
   endtask

   // Lone events at reset settings: unused code, clocks outside a packet,
   // a short byte, a read of a zero key word
   task automatic test_single_events();
      send_event(KIND_NONE, 1'b1, 1'b1);
      send_event(KIND_NONE, 1'b0, 1'b0);
      send_event(KIND_CLOCK_EDGE, 1'b1, 1'b1);
      send_event(KIND_CLOCK_EDGE, 1'b0, 1'b1);
      send_event(KIND_SELECT_FALL, 1'b0, 1'b0);
      send_event(KIND_CLOCK_EDGE, 1'b0, 1'b1);
      send_event(KIND_CLOCK_EDGE, 1'b1, 1'b1);
      send_event(KIND_SELECT_RISE, 1'b0, 1'b0);
      send_event(KIND_SELECT_FALL, 1'b1, 1'b1);
      repeat (8) send_event(KIND_CLOCK_EDGE, 1'b1, 1'b0);
      send_event(KIND_CLOCK_EDGE, 1'b0, 1'b0);
      send_event(KIND_CLOCK_EDGE, 1'b1, 1'b1);
      send_event(KIND_SELECT_RISE, 1'b1, 1'b0);
   endtask

   task automatic test_frames();
      send_frame(PAYLOAD_BYTES, 0, 8'h00);
      send_frame(PAYLOAD_BYTES, 0, 8'hFF);
   endtask

   // Includes a read long enough to wrap the key bit position
   task automatic test_read_requests();
      send_read(0);
      send_read(20);
      send_read($urandom_range(1, 16));
   endtask

   // Short payload with stray bits, too many payload bytes, short command
   task automatic test_count_errors();
      send_frame(4, 5, 8'h33);
      send_frame(PAYLOAD_BYTES + 2, 0, 8'h34);
      send_command(pick_byte(), $urandom_range(1, 7));
   endtask

   task automatic test_equal_commands();
      logic [7:0] x;
      x = 8'($urandom_range(0, 255));
      set_config(x, x, x, 16'($urandom_range(0, 65535)));
      send_frame(2, 0, 8'($urandom_range(0, 255)));
      set_config(x, x ^ 8'h01, x ^ 8'h01, 16'($urandom_range(0, 65535)));
      send_frame(2, 0, x ^ 8'h80);
   endtask

   // Receiver holds off while events keep coming back to back
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      hold_request = HOLD_CYCLES;
      send_command(pick_byte(), 8);
      send_read(8);
      drain_results();
      req_idle_on = 1'b1;
   endtask

   // Mostly whole frames and reads, some broken ones, some loose events
   task automatic test_random_traffic(input int nitems);
      int stop;
      int n;
      int extra;
      stop = sent_count + nitems;
      while (sent_count < stop) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               if ($urandom_range(0, 3) == 0) begin
                  n = $urandom_range(0, PAYLOAD_BYTES + 2);
                  extra = $urandom_range(0, 7);
               end else begin
                  n = PAYLOAD_BYTES;
                  extra = 0;
               end
               send_frame(n, extra, pick_byte());
            end
            5, 6: send_read($urandom_range(0, 20));
            7: send_command(pick_byte(), $urandom_range(1, 8));
            default: repeat ($urandom_range(1, 6))
               send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
         endcase
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Result side: random stalls, optional long hold, check on each accept
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else begin
            stall = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         check_result();
      end
   end

   // Ends the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int left;
      req_chan.valid       = 1'b0;
      req_chan.kind        = KIND_SELECT_FALL;
      req_chan.clock_level = 1'b0;
      req_chan.data_bit    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_single_events();
      set_config(8'h5A, 8'hA5, 8'h3C, 16'hFFFF);
      test_frames();
      set_config(8'h5A, 8'hA5, 8'h3C, 16'($urandom_range(0, 65535)));
      test_read_requests();
      set_config(8'h00, 8'hFF, 8'h81, 16'h0000);
      test_count_errors();
      test_equal_commands();
      test_backpressure();
      // Random traffic fills the rest of the item budget
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      left = ITEM_TARGET - sent_count;
      test_random_traffic((left > 2) ? left / 2 : 1);
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hFF,
                 16'($urandom_range(0, 65535)));
      left = ITEM_TARGET - sent_count;
      test_random_traffic((left > 1) ? left : 1);
      drain_results();

      $display("run covered %0d pin events and %0d results under %0d register settings",
               sent_count, checked_count, settings_used);
      $display("frames closed: %0d, key reads started: %0d", frames_closed, reads_started);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dbsr_pkg.sv
rtl/dbsr_req_if.sv
rtl/dbsr_rsp_if.sv
rtl/dbsr_core.sv
rtl/dbsr_out_stage.sv
rtl/display_bus_slave_receiver.sv
tb/testbench.sv
